@@ rtl/dqdp_pkg.sv @@
// Package with shared constants, control types and state codes of the dequantizing dot product.
`timescale 1ns / 1ps

package dqdp_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int X_W           = 16;
    localparam int CODE_W        = 8;
    localparam int COEF_W        = 16;
    localparam int COL_W         = 12;
    localparam int SUM_W         = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_T1,
        S_T2,
        S_DEQ,
        S_PROD,
        S_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic t1;
        logic t2;
        logic deq;
        logic prod;
        logic acc;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

endpackage

@@ rtl/dqdp_in_if.sv @@
// Input channel interface carrying one row element item.
`timescale 1ns / 1ps

interface dqdp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_value;
    logic        [7:0]  weight_code;
    logic signed [15:0] row_scale;
    logic signed [15:0] row_offset;
    logic signed [15:0] col_scale;
    logic signed [15:0] col_offset;
    logic        [11:0] column_index;
    logic               last_element;

    modport source (
        output valid, x_value, weight_code, row_scale, row_offset,
               col_scale, col_offset, column_index, last_element,
        input  ready
    );

    modport sink (
        input  valid, x_value, weight_code, row_scale, row_offset,
               col_scale, col_offset, column_index, last_element,
        output ready
    );
endinterface

@@ rtl/dqdp_out_if.sv @@
// Output channel interface carrying one column result item.
`timescale 1ns / 1ps

interface dqdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] dot_result;
    logic        [11:0] result_column;
    logic               overflow_flag;

    modport source (
        output valid, dot_result, result_column, overflow_flag,
        input  ready
    );

    modport sink (
        input  valid, dot_result, result_column, overflow_flag,
        output ready
    );
endinterface

@@ rtl/dqdp_ctrl.sv @@
// Controller state machine that steps one item through the datapath stages.
`timescale 1ns / 1ps

module dqdp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  dqdp_pkg::t_dp_status   i_status,
    output dqdp_pkg::t_dp_cmd      o_cmd
);
    import dqdp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_T1;
                end
            end
            S_T1: begin
                o_cmd.t1 = 1'b1;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.t2 = 1'b1;
                n_state  = S_DEQ;
            end
            S_DEQ: begin
                o_cmd.deq = 1'b1;
                n_state   = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                if (!i_status.out_stall) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dqdp_dp.sv @@
// Datapath with the dequantize multipliers, the saturating accumulator and the result register.
`timescale 1ns / 1ps

module dqdp_dp #(
    parameter int FRACTION_BITS = dqdp_pkg::FRACTION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dqdp_pkg::t_dp_cmd                      i_cmd,
    output dqdp_pkg::t_dp_status                   o_status,
    input  logic signed [dqdp_pkg::X_W-1:0]        i_x_value,
    input  logic        [dqdp_pkg::CODE_W-1:0]     i_weight_code,
    input  logic signed [dqdp_pkg::COEF_W-1:0]     i_row_scale,
    input  logic signed [dqdp_pkg::COEF_W-1:0]     i_row_offset,
    input  logic signed [dqdp_pkg::COEF_W-1:0]     i_col_scale,
    input  logic signed [dqdp_pkg::COEF_W-1:0]     i_col_offset,
    input  logic        [dqdp_pkg::COL_W-1:0]      i_column_index,
    input  logic                                   i_last_element,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [dqdp_pkg::SUM_W-1:0]      o_dot_result,
    output logic        [dqdp_pkg::COL_W-1:0]      o_result_column,
    output logic                                   o_overflow_flag
);
    import dqdp_pkg::*;

    localparam int W_WQ   = CODE_W + FRACTION_BITS + 1;
    localparam int W_P1   = W_WQ + COEF_W;
    localparam int W_T1   = W_P1 - FRACTION_BITS;
    localparam int W_P2   = W_T1 + COEF_W;
    localparam int W_T2   = W_P2 - FRACTION_BITS;
    localparam int W_DEQ  = W_T2 + 1;
    localparam int W_P3   = W_DEQ + X_W;
    localparam int W_PROD = W_P3 - FRACTION_BITS;
    localparam int W_SUM  = ((W_PROD > SUM_W) ? W_PROD : SUM_W) + 1;

    logic signed [X_W-1:0]    r_x;
    logic        [CODE_W-1:0] r_code;
    logic signed [COEF_W-1:0] r_rs;
    logic signed [COEF_W-1:0] r_ro;
    logic signed [COEF_W-1:0] r_cs;
    logic signed [COEF_W-1:0] r_co;
    logic        [COL_W-1:0]  r_col;
    logic                     r_last;

    logic signed [W_T1-1:0]   r_t1;
    logic signed [W_T2-1:0]   r_t2;
    logic signed [W_DEQ-1:0]  r_deq;
    logic signed [W_PROD-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_sat;

    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_dot;
    logic        [COL_W-1:0]  r_out_col;
    logic                     r_ovf;

    logic signed [W_WQ-1:0]   wq;
    logic signed [W_P1-1:0]   p1;
    logic signed [W_P2-1:0]   p2;
    logic signed [W_DEQ-1:0]  deq;
    logic signed [W_P3-1:0]   p3;
    logic signed [W_SUM-1:0]  sum;
    logic                     sat_now;
    logic signed [SUM_W-1:0]  sum_sat;

    // The weight code plus one half, exact in the fixed-point fraction.
    assign wq  = signed'({1'b0, r_code, 1'b1, {(FRACTION_BITS - 1){1'b0}}});
    assign p1  = wq * r_rs;
    assign p2  = r_t1 * r_cs;
    assign deq = W_DEQ'(r_t2) + W_DEQ'(r_ro) + W_DEQ'(r_co);
    assign p3  = r_x * r_deq;
    assign sum = W_SUM'(r_sum) + W_SUM'(r_prod);

    // The sum fits when all bits above the result sign agree with it.
    assign sat_now = !((&sum[W_SUM-1:SUM_W-1]) || !(|sum[W_SUM-1:SUM_W-1]));
    assign sum_sat = sat_now ? (sum[W_SUM-1] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                             : {1'b0, {(SUM_W - 1){1'b1}}})
                             : sum[SUM_W-1:0];

    assign o_status.out_stall = r_last && r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_x_value;
            r_code <= i_weight_code;
            r_rs   <= i_row_scale;
            r_ro   <= i_row_offset;
            r_cs   <= i_col_scale;
            r_co   <= i_col_offset;
            r_col  <= i_column_index;
            r_last <= i_last_element;
        end
        if (i_cmd.t1) begin
            r_t1 <= p1[W_P1-1:FRACTION_BITS];
        end
        if (i_cmd.t2) begin
            r_t2 <= p2[W_P2-1:FRACTION_BITS];
        end
        if (i_cmd.deq) begin
            r_deq <= deq;
        end
        if (i_cmd.prod) begin
            r_prod <= p3[W_P3-1:FRACTION_BITS];
        end
        if (i_cmd.acc && r_last) begin
            r_dot     <= sum_sat;
            r_out_col <= r_col;
            r_ovf     <= r_sat || sat_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (r_last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= sum_sat;
                    r_sat <= r_sat || sat_now;
                end
            end
            if (i_cmd.acc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_dot_result    = r_dot;
    assign o_result_column = r_out_col;
    assign o_overflow_flag = r_ovf;

endmodule

@@ rtl/dequant_int8_dot_product.sv @@
// Top level of the dequantizing 8-bit dot product that joins controller and datapath.
//
//  channel  | direction | payload                                           | item
//  i_in     | sink      | x, weight code, scales, offsets, column, last     | one row element
//  o_out    | source    | dot_result, result_column, overflow_flag          | one column sum
//
// Each item is captured, then passes four multiply and add stages and the accumulate
// step of the single shared datapath, which works on one item at a time; each result
// is offered through an output register that the accumulate step of its last item sets.
// Reset is synchronous and active low and clears the sum, its saturation and the control.
// A stalled result holds the accumulate step of the next last item until it is taken.
`timescale 1ns / 1ps

module dequant_int8_dot_product #(
    parameter int FRACTION_BITS = dqdp_pkg::FRACTION_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqdp_in_if.sink    i_in,
    dqdp_out_if.source o_out
);
    import dqdp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    assign i_in.ready = w_ready;

    dqdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dqdp_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_x_value       (i_in.x_value),
        .i_weight_code   (i_in.weight_code),
        .i_row_scale     (i_in.row_scale),
        .i_row_offset    (i_in.row_offset),
        .i_col_scale     (i_in.col_scale),
        .i_col_offset    (i_in.col_offset),
        .i_column_index  (i_in.column_index),
        .i_last_element  (i_in.last_element),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_dot_result    (o_out.dot_result),
        .o_result_column (o_out.result_column),
        .o_overflow_flag (o_out.overflow_flag)
    );

endmodule

@@ rtl/dqdp_checker.sv @@
// Port checker for the dequantizing dot product and its bind to the top level.
`timescale 1ns / 1ps

module dqdp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A waiting result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result item withdrawn before it was taken");

    // The block works on one item at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item taken while the previous one is still in work");

    // Ready only drops because an item was taken.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("ready dropped without an accepted item");

    // A fresh result follows a last item through the capture, datapath and accumulate steps.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 6))
        else $error("result item without a matching last item");

endmodule

bind dequant_int8_dot_product dqdp_checker u_dqdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_element),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
